/* hw/rtl/tswm_pkg.sv */
// Shared types, constants and helper functions of the tile similarity weighted merge.
// No dependencies; every other file but tswm_ram takes names from here by scope.
package tswm_pkg;

	localparam int MAX_TILE_PIXELS = 64;
	localparam int MAX_CHANNELS    = 3;
	localparam int PIXEL_BITS      = 16;

	localparam int ERR_W     = 40;
	localparam int DND_W     = 56;
	localparam int T_W       = 89;
	localparam int RQ_W      = 88;
	localparam int DQ_W      = 109;
	localparam int Q_W       = 21;
	localparam int MSE_STEPS = 56;
	localparam int Q_STEPS   = 21;
	localparam int SQ_STEPS  = 8;
	localparam int STEP_W    = 6;

	localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
	localparam logic [16:0] WEIGHT_ONE = 17'h1_0000;
	localparam logic [33:0] ROUND_HALF = 34'd32768;
	localparam logic [31:0] RECIP_6    = 32'd715827882;
	localparam logic [31:0] RECIP_24   = 32'd178956970;
	localparam logic [35:0] DIV_6      = 36'd6;
	localparam logic [35:0] DIV_24     = 36'd24;

	localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd1080;
	localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd1920;
	localparam logic [3:0]  RST_TILE_DIM     = 4'd8;
	localparam logic [1:0]  RST_CHANNELS     = 2'd3;
	localparam logic [31:0] RST_Q16_ONE      = 32'd65536;

	typedef enum logic [2:0] {
		REG_IMAGE_HEIGHT  = 3'd0,
		REG_IMAGE_WIDTH   = 3'd1,
		REG_TILE_HEIGHT   = 3'd2,
		REG_TILE_WIDTH    = 3'd3,
		REG_CHANNEL_COUNT = 3'd4,
		REG_MOTION_LIMIT  = 3'd5,
		REG_NOISE_GAIN    = 3'd6,
		REG_OUTPUT_SCALE  = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MSE_INIT,
		OP_MSE_STEP,
		OP_T_LO,
		OP_T_HI,
		OP_Q_INIT,
		OP_Q_STEP,
		OP_Y2,
		OP_Y3,
		OP_Y4,
		OP_D6,
		OP_D24,
		OP_POLY,
		OP_SQ,
		OP_W_EXP,
		OP_EMIT,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic [11:0] tile_row;
		logic [11:0] tile_col;
		logic [15:0] cur_ch0;
		logic [15:0] cur_ch1;
		logic [15:0] cur_ch2;
		logic [15:0] ref_ch0;
		logic [15:0] ref_ch1;
		logic [15:0] ref_ch2;
		logic [15:0] window_value;
		logic        last_of_tile;
	} pixel_t;

	typedef struct packed {
		logic [11:0] pixel_row;
		logic [11:0] pixel_col;
		logic [47:0] contrib_ch0;
		logic [47:0] contrib_ch1;
		logic [47:0] contrib_ch2;
		logic [16:0] weight_contrib;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic [12:0] image_height;
		logic [12:0] image_width;
		logic [3:0]  tile_height;
		logic [3:0]  tile_width;
		logic [1:0]  channel_count;
		logic [31:0] motion_limit;
		logic [31:0] noise_gain;
		logic [31:0] output_scale;
	} cfg_t;

	typedef struct packed {
		logic oob;
		logic err_zero;
		logic t_zero;
		logic q_big;
		logic emit_last;
	} stat_t;

	function automatic logic [3:0] clamp_dim(input logic [3:0] v);
		if (v == 4'd0) begin
			return 4'd1;
		end else if (v > 4'd8) begin
			return 4'd8;
		end
		return v;
	endfunction

	function automatic logic [1:0] chan_used(input logic [1:0] c);
		if (c == 2'd0) begin
			return 2'd1;
		end else if (c > 2'(MAX_CHANNELS)) begin
			return 2'(MAX_CHANNELS);
		end
		return c;
	endfunction

endpackage

/* hw/rtl/tile_similarity_weighted_merge.sv */
// Top level of the tile similarity weighted merge: register file, sequencer, datapath.
// Depends on tswm_pkg, tswm_ctrl, tswm_dp.
//
//  channel  | signals                      | transaction taken when
//  ---------+------------------------------+--------------------------------
//  pixel in | start, busy, pixel           | start high and busy low
//  result   | strobe, result               | strobe high (one cycle each)
//  config   | cfg_we, cfg_index, cfg_data  | cfg_we high
//
// Pixels are taken while the block is idle. After the last pixel of a tile the block
// stays busy while it runs a radix-2 mean divider, a quotient unit
// and an eight-step squaring chain
// on one shared 32x32 multiplier, then one result per cycle out of a five-stage
// pipeline. A tile that crosses the image edge is cleared with no results. Reset
// clears the sequencer, counters and registers to their defaults. The receiver cannot stall.
module tile_similarity_weighted_merge #(
	parameter int MAX_TILE_PIXELS = tswm_pkg::MAX_TILE_PIXELS,
	parameter int PIXEL_BITS      = tswm_pkg::PIXEL_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tswm_pkg::pixel_t  pixel,
	output logic              strobe,
	output tswm_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	tswm_pkg::cfg_t  cfg_q;
	tswm_pkg::stat_t stat;
	tswm_pkg::op_t   op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_height  <= tswm_pkg::RST_IMAGE_HEIGHT;
			cfg_q.image_width   <= tswm_pkg::RST_IMAGE_WIDTH;
			cfg_q.tile_height   <= tswm_pkg::RST_TILE_DIM;
			cfg_q.tile_width    <= tswm_pkg::RST_TILE_DIM;
			cfg_q.channel_count <= tswm_pkg::RST_CHANNELS;
			cfg_q.motion_limit  <= tswm_pkg::RST_Q16_ONE;
			cfg_q.noise_gain    <= tswm_pkg::RST_Q16_ONE;
			cfg_q.output_scale  <= tswm_pkg::RST_Q16_ONE;
		end else if (cfg_we) begin
			case (tswm_pkg::reg_idx_t'(cfg_index))
				tswm_pkg::REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[12:0];
				tswm_pkg::REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[12:0];
				tswm_pkg::REG_TILE_HEIGHT:   cfg_q.tile_height   <= cfg_data[3:0];
				tswm_pkg::REG_TILE_WIDTH:    cfg_q.tile_width    <= cfg_data[3:0];
				tswm_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[1:0];
				tswm_pkg::REG_MOTION_LIMIT:  cfg_q.motion_limit  <= cfg_data;
				tswm_pkg::REG_NOISE_GAIN:    cfg_q.noise_gain    <= cfg_data;
				tswm_pkg::REG_OUTPUT_SCALE:  cfg_q.output_scale  <= cfg_data;
				default: ;
			endcase
		end
	end

	tswm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (pixel.last_of_tile),
		.stat   (stat),
		.busy   (busy),
		.op     (op)
	);

	tswm_dp #(
		.MAX_TILE_PIXELS (MAX_TILE_PIXELS),
		.PIXEL_BITS      (PIXEL_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.cfg    (cfg_q),
		.pixel  (pixel),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

endmodule

/* hw/rtl/tswm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tswm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/tswm_ctrl.sv */
// Sequencer of the tile merge: load, error mean, weight evaluation, emission.
// Depends on tswm_pkg.
module tswm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            last,
	input  tswm_pkg::stat_t stat,
	output logic            busy,
	output tswm_pkg::op_t   op
);

	typedef enum logic [17:0] {
		S_IDLE  = 18'd1,
		S_WAIT  = 18'd2,
		S_CHECK = 18'd4,
		S_MSE   = 18'd8,
		S_TLO   = 18'd16,
		S_THI   = 18'd32,
		S_QINIT = 18'd64,
		S_Q     = 18'd128,
		S_Y2    = 18'd256,
		S_Y3    = 18'd512,
		S_Y4    = 18'd1024,
		S_D6    = 18'd2048,
		S_D24   = 18'd4096,
		S_POLY  = 18'd8192,
		S_SQ    = 18'd16384,
		S_WEXP  = 18'd32768,
		S_EMIT  = 18'd65536,
		S_CLEAR = 18'd131072
	} state_t;

	state_t                         state_q, state_d;
	logic [tswm_pkg::STEP_W-1:0]    step_q;

	always_comb begin
		state_d = state_q;
		op      = tswm_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op = tswm_pkg::OP_LOAD;
					if (last) begin
						state_d = S_WAIT;
					end
				end
			end
			S_WAIT: state_d = S_CHECK;
			S_CHECK: begin
				op = tswm_pkg::OP_MSE_INIT;
				if (stat.oob) begin
					state_d = S_CLEAR;
				end else if (stat.err_zero) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_MSE;
				end
			end
			S_MSE: begin
				op = tswm_pkg::OP_MSE_STEP;
				if (step_q == tswm_pkg::STEP_W'(tswm_pkg::MSE_STEPS - 1)) begin
					state_d = S_TLO;
				end
			end
			S_TLO: begin
				op      = tswm_pkg::OP_T_LO;
				state_d = S_THI;
			end
			S_THI: begin
				op      = tswm_pkg::OP_T_HI;
				state_d = S_QINIT;
			end
			S_QINIT: begin
				op      = tswm_pkg::OP_Q_INIT;
				state_d = stat.t_zero ? S_EMIT : S_Q;
			end
			S_Q: begin
				op = tswm_pkg::OP_Q_STEP;
				if (step_q == tswm_pkg::STEP_W'(tswm_pkg::Q_STEPS - 1)) begin
					state_d = S_Y2;
				end
			end
			S_Y2: begin
				op      = tswm_pkg::OP_Y2;
				state_d = stat.q_big ? S_EMIT : S_Y3;
			end
			S_Y3: begin
				op      = tswm_pkg::OP_Y3;
				state_d = S_Y4;
			end
			S_Y4: begin
				op      = tswm_pkg::OP_Y4;
				state_d = S_D6;
			end
			S_D6: begin
				op      = tswm_pkg::OP_D6;
				state_d = S_D24;
			end
			S_D24: begin
				op      = tswm_pkg::OP_D24;
				state_d = S_POLY;
			end
			S_POLY: begin
				op      = tswm_pkg::OP_POLY;
				state_d = S_SQ;
			end
			S_SQ: begin
				op = tswm_pkg::OP_SQ;
				if (step_q == tswm_pkg::STEP_W'(tswm_pkg::SQ_STEPS - 1)) begin
					state_d = S_WEXP;
				end
			end
			S_WEXP: begin
				op      = tswm_pkg::OP_W_EXP;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				op = tswm_pkg::OP_EMIT;
				if (stat.emit_last) begin
					state_d = S_CLEAR;
				end
			end
			S_CLEAR: begin
				op      = tswm_pkg::OP_CLEAR;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + tswm_pkg::STEP_W'(1);
			end
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* hw/rtl/tswm_dp.sv */
// Datapath of the tile merge: tile store, error sum, weight units, emission pipeline.
// Depends on tswm_pkg and tswm_ram.
module tswm_dp #(
	parameter int MAX_TILE_PIXELS = tswm_pkg::MAX_TILE_PIXELS,
	parameter int PIXEL_BITS      = tswm_pkg::PIXEL_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tswm_pkg::op_t     op,
	input  tswm_pkg::cfg_t    cfg,
	input  tswm_pkg::pixel_t  pixel,
	output tswm_pkg::stat_t   stat,
	output logic              strobe,
	output tswm_pkg::result_t result
);

	localparam int AW  = (MAX_TILE_PIXELS > 1) ? $clog2(MAX_TILE_PIXELS) : 1;
	localparam int CW  = $clog2(MAX_TILE_PIXELS + 1);
	localparam int DVW = CW + 2;
	localparam int RW  = 3 * PIXEL_BITS + 16;
	localparam int SQW = 2 * PIXEL_BITS;
	localparam int AXW = PIXEL_BITS + 17;
	localparam int PXW = AXW + 32;

	logic [PIXEL_BITS-1:0] cur [3];
	logic [PIXEL_BITS-1:0] rfv [3];
	logic [SQW-1:0]        sq  [3];
	logic [1:0]            ch;
	logic [3:0]            th, tw;
	logic                  store_en;

	logic [CW-1:0]               cnt_q;
	logic                        oob_q;
	logic [11:0]                 orow_q, ocol_q;
	logic [SQW-1:0]              sq_s1 [3];
	logic                        sqv_s1;
	logic [tswm_pkg::ERR_W-1:0]  err_q;

	logic [DVW-1:0]              divr_q, rem_q;
	logic [DVW:0]                remsh;
	logic [tswm_pkg::DND_W-1:0]  dnd_q;
	logic [tswm_pkg::T_W-1:0]    t_q;
	logic [tswm_pkg::RQ_W-1:0]   rq_q;
	logic [tswm_pkg::DQ_W-1:0]   dq_q;
	logic [tswm_pkg::Q_W-1:0]    q_q;
	logic                        q_ge;
	logic [31:0]                 y, y2_q, y3_q, y4_q, e6_q, e24_q, d6, d24;
	logic [35:0]                 r6, r24;
	logic [33:0]                 pnew;
	logic [32:0]                 p_q;
	logic [16:0]                 weight_q;
	logic [31:0]                 mul_a, mul_b;
	logic [63:0]                 prod;

	logic [AW-1:0]               ea_q, rowc_q;
	logic [2:0]                  colc_q;
	logic                        emit_last;
	logic [RW-1:0]               wdata, rdata;

	logic                        v1_s1, v2_s2, v3_s3, v4_s4, strobe_q;
	logic [11:0]                 row_s1, col_s1, row_s2, col_s2, row_s3, col_s3, row_s4, col_s4;
	logic                        last_s1, last_s2, last_s3, last_s4;
	logic [16:0]                 wc_s2, wc_s3, wc_s4;
	logic [PIXEL_BITS-1:0]       cur_s2 [3];
	logic [AXW-1:0]              a_s3 [3];
	logic [PXW-1:0]              pr_s4 [3];
	logic [65:0]                 pr_ext [3];
	logic [47:0]                 ctb [3];
	logic [32:0]                 wprod;
	tswm_pkg::result_t           res_q;

	assign cur[0] = pixel.cur_ch0[PIXEL_BITS-1:0];
	assign cur[1] = pixel.cur_ch1[PIXEL_BITS-1:0];
	assign cur[2] = pixel.cur_ch2[PIXEL_BITS-1:0];
	assign rfv[0] = pixel.ref_ch0[PIXEL_BITS-1:0];
	assign rfv[1] = pixel.ref_ch1[PIXEL_BITS-1:0];
	assign rfv[2] = pixel.ref_ch2[PIXEL_BITS-1:0];

	assign ch = tswm_pkg::chan_used(cfg.channel_count);
	assign th = tswm_pkg::clamp_dim(cfg.tile_height);
	assign tw = tswm_pkg::clamp_dim(cfg.tile_width);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic [PIXEL_BITS-1:0] d;
			d     = (cur[j] > rfv[j]) ? (cur[j] - rfv[j]) : (rfv[j] - cur[j]);
			sq[j] = SQW'(d) * SQW'(d);
		end
	end

	assign store_en  = (op == tswm_pkg::OP_LOAD) && (cnt_q < CW'(MAX_TILE_PIXELS));
	assign wdata     = {pixel.window_value, cur[2], cur[1], cur[0]};
	assign emit_last = ((CW'(ea_q) + CW'(1)) == cnt_q);

	tswm_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_TILE_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (store_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata (wdata),
		.raddr (ea_q),
		.rdata (rdata)
	);

	assign remsh = {rem_q, dnd_q[tswm_pkg::DND_W-1]};
	assign q_ge  = ({21'd0, rq_q} >= dq_q);
	assign y     = {4'd0, q_q[19:0], 8'd0};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			tswm_pkg::OP_T_LO: begin
				mul_a = cfg.noise_gain;
				mul_b = dnd_q[31:0];
			end
			tswm_pkg::OP_T_HI: begin
				mul_a = cfg.noise_gain;
				mul_b = 32'(dnd_q[tswm_pkg::DND_W-1:32]);
			end
			tswm_pkg::OP_Y2: begin
				mul_a = y;
				mul_b = y;
			end
			tswm_pkg::OP_Y3: begin
				mul_a = y2_q;
				mul_b = y;
			end
			tswm_pkg::OP_Y4: begin
				mul_a = y3_q;
				mul_b = y;
			end
			tswm_pkg::OP_D6: begin
				mul_a = y3_q;
				mul_b = tswm_pkg::RECIP_6;
			end
			tswm_pkg::OP_D24: begin
				mul_a = y4_q;
				mul_b = tswm_pkg::RECIP_24;
			end
			tswm_pkg::OP_SQ: begin
				mul_a = p_q[31:0];
				mul_b = p_q[31:0];
			end
			default: ;
		endcase
	end

	assign prod = 64'(mul_a) * 64'(mul_b);

	assign r6   = 36'(y3_q) - 36'(e6_q) * tswm_pkg::DIV_6;
	assign r24  = 36'(y4_q) - 36'(e24_q) * tswm_pkg::DIV_24;
	assign d6   = (r6 >= tswm_pkg::DIV_6) ? (e6_q + 32'd1) : e6_q;
	assign d24  = (r24 >= tswm_pkg::DIV_24) ? (e24_q + 32'd1) : e24_q;
	assign pnew = 34'(tswm_pkg::ONE_Q32) - 34'(y) + 34'(y2_q >> 1) + 34'(d24) - 34'(d6);

	assign wprod = 33'(rdata[RW-1:RW-16]) * 33'(weight_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			oob_q    <= 1'b0;
			sqv_s1   <= 1'b0;
			err_q    <= '0;
			ea_q     <= '0;
			rowc_q   <= '0;
			colc_q   <= '0;
			v1_s1    <= 1'b0;
			v2_s2    <= 1'b0;
			v3_s3    <= 1'b0;
			v4_s4    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			sqv_s1   <= store_en;
			v1_s1    <= (op == tswm_pkg::OP_EMIT);
			v2_s2    <= v1_s1;
			v3_s3    <= v2_s2;
			v4_s4    <= v3_s3;
			strobe_q <= v4_s4;
			if (sqv_s1) begin
				err_q <= err_q + tswm_pkg::ERR_W'(sq_s1[0]) + tswm_pkg::ERR_W'(sq_s1[1])
					+ tswm_pkg::ERR_W'(sq_s1[2]);
			end
			case (op)
				tswm_pkg::OP_LOAD: begin
					if (cnt_q == '0) begin
						oob_q <= ((14'(pixel.tile_row) + 14'(th)) > 14'(cfg.image_height))
							|| ((14'(pixel.tile_col) + 14'(tw)) > 14'(cfg.image_width));
					end
					if (store_en) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				tswm_pkg::OP_EMIT: begin
					ea_q <= ea_q + AW'(1);
					if ((4'(colc_q) + 4'd1) == tw) begin
						colc_q <= '0;
						rowc_q <= rowc_q + AW'(1);
					end else begin
						colc_q <= colc_q + 3'd1;
					end
				end
				tswm_pkg::OP_CLEAR: begin
					cnt_q  <= '0;
					oob_q  <= 1'b0;
					err_q  <= '0;
					ea_q   <= '0;
					rowc_q <= '0;
					colc_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			for (int j = 0; j < 3; j++) begin
				sq_s1[j] <= (2'(j) < ch) ? sq[j] : '0;
			end
		end
		case (op)
			tswm_pkg::OP_LOAD: begin
				if (cnt_q == '0) begin
					orow_q <= pixel.tile_row;
					ocol_q <= pixel.tile_col;
				end
			end
			tswm_pkg::OP_MSE_INIT: begin
				divr_q   <= DVW'(cnt_q) * DVW'(ch);
				rem_q    <= '0;
				dnd_q    <= {err_q, 16'd0};
				weight_q <= tswm_pkg::WEIGHT_ONE;
			end
			tswm_pkg::OP_MSE_STEP: begin
				if (remsh >= (DVW + 1)'(divr_q)) begin
					rem_q <= DVW'(remsh - (DVW + 1)'(divr_q));
					dnd_q <= {dnd_q[tswm_pkg::DND_W-2:0], 1'b1};
				end else begin
					rem_q <= DVW'(remsh);
					dnd_q <= {dnd_q[tswm_pkg::DND_W-2:0], 1'b0};
				end
			end
			tswm_pkg::OP_T_LO: t_q <= tswm_pkg::T_W'(prod) + tswm_pkg::T_W'({cfg.motion_limit, 16'd0});
			tswm_pkg::OP_T_HI: t_q <= t_q + tswm_pkg::T_W'({prod, 32'd0});
			tswm_pkg::OP_Q_INIT: begin
				rq_q     <= {dnd_q, 32'd0};
				dq_q     <= {t_q, 20'd0};
				q_q      <= '0;
				weight_q <= '0;
			end
			tswm_pkg::OP_Q_STEP: begin
				if (q_ge) begin
					rq_q <= rq_q - dq_q[tswm_pkg::RQ_W-1:0];
				end
				dq_q <= dq_q >> 1;
				q_q  <= {q_q[tswm_pkg::Q_W-2:0], q_ge};
			end
			tswm_pkg::OP_Y2:   y2_q  <= prod[63:32];
			tswm_pkg::OP_Y3:   y3_q  <= prod[63:32];
			tswm_pkg::OP_Y4:   y4_q  <= prod[63:32];
			tswm_pkg::OP_D6:   e6_q  <= prod[63:32];
			tswm_pkg::OP_D24:  e24_q <= prod[63:32];
			tswm_pkg::OP_POLY: p_q   <= 33'(pnew);
			tswm_pkg::OP_SQ: begin
				if (!p_q[32]) begin
					p_q <= {1'b0, prod[63:32]};
				end
			end
			tswm_pkg::OP_W_EXP: weight_q <= 17'((34'(p_q) + tswm_pkg::ROUND_HALF) >> 16);
			tswm_pkg::OP_EMIT: begin
				row_s1  <= orow_q + 12'(rowc_q);
				col_s1  <= ocol_q + 12'(colc_q);
				last_s1 <= emit_last;
			end
			default: ;
		endcase

		row_s2  <= row_s1;
		col_s2  <= col_s1;
		last_s2 <= last_s1;
		wc_s2   <= wprod[31:15];
		for (int j = 0; j < 3; j++) begin
			cur_s2[j] <= (2'(j) < ch) ? rdata[j*PIXEL_BITS +: PIXEL_BITS] : '0;
		end

		row_s3  <= row_s2;
		col_s3  <= col_s2;
		last_s3 <= last_s2;
		wc_s3   <= wc_s2;
		for (int j = 0; j < 3; j++) begin
			a_s3[j] <= AXW'(cur_s2[j]) * AXW'(wc_s2);
		end

		row_s4  <= row_s3;
		col_s4  <= col_s3;
		last_s4 <= last_s3;
		wc_s4   <= wc_s3;
		for (int j = 0; j < 3; j++) begin
			pr_s4[j] <= PXW'(a_s3[j]) * PXW'(cfg.output_scale);
		end

		res_q.pixel_row      <= row_s4;
		res_q.pixel_col      <= col_s4;
		res_q.contrib_ch0    <= ctb[0];
		res_q.contrib_ch1    <= ctb[1];
		res_q.contrib_ch2    <= ctb[2];
		res_q.weight_contrib <= wc_s4;
		res_q.last_result    <= last_s4;
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			pr_ext[j] = 66'(pr_s4[j]);
			ctb[j]    = (|pr_ext[j][65:64]) ? '1 : pr_ext[j][63:16];
		end
	end

	assign stat.oob       = oob_q;
	assign stat.err_zero  = (err_q == '0);
	assign stat.t_zero    = (t_q == '0);
	assign stat.q_big     = q_q[tswm_pkg::Q_W-1];
	assign stat.emit_last = emit_last;

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

/* hw/rtl/tswm_chk.sv */
// Port-level checks of the tile similarity weighted merge, bound to the top level.
// Depends on tswm_pkg and tile_similarity_weighted_merge.
module tswm_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input tswm_pkg::pixel_t  pixel,
	input logic              strobe,
	input tswm_pkg::result_t result
);

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_result |=> !strobe)
		else $error("result after the last transaction of a tile");

	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_result |=> strobe)
		else $error("gap inside a tile's results");

	a_last_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && pixel.last_of_tile |=> busy)
		else $error("busy not raised after the last pixel");

	a_zero_weight: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.weight_contrib == 17'd0) |->
		(result.contrib_ch0 == 48'd0) && (result.contrib_ch1 == 48'd0)
		&& (result.contrib_ch2 == 48'd0))
		else $error("nonzero contribution with zero weight");

endmodule

bind tile_similarity_weighted_merge tswm_chk u_chk (.*);

/* sim/tb_tile_similarity_weighted_merge.sv */
// Self-checking testbench for tile_similarity_weighted_merge: tiles of random pixels
// go in over the pixel port, every emitted contribution is checked field by field.
// Depends on tswm_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_tile_similarity_weighted_merge;

	typedef enum int {
		DIFF_EQUAL,
		DIFF_SMALL,
		DIFF_RANDOM,
		DIFF_FULL
	} diff_t;

	class merge_scoreboard;
		logic [12:0] img_h, img_w;
		logic [3:0]  t_h, t_w;
		logic [1:0]  chans;
		logic [31:0] motion, noise, scale;
		logic [47:0] pix_mem [64];
		logic [15:0] win_mem [64];
		logic [39:0] err_acc;
		int unsigned loaded;
		logic [11:0] org_r, org_c;
		bit          crosses_border;
		tswm_pkg::result_t pending [$];
		int          errors;

		function new();
			img_h = 13'd1080;
			img_w = 13'd1920;
			t_h = 4'd8;
			t_w = 4'd8;
			chans = 2'd3;
			motion = 32'd65536;
			noise = 32'd65536;
			scale = 32'd65536;
			err_acc = '0;
			loaded = 0;
			org_r = '0;
			org_c = '0;
			crosses_border = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(tswm_pkg::reg_idx_t idx, logic [31:0] v);
			case (idx)
				tswm_pkg::REG_IMAGE_HEIGHT:  img_h = v[12:0];
				tswm_pkg::REG_IMAGE_WIDTH:   img_w = v[12:0];
				tswm_pkg::REG_TILE_HEIGHT:   t_h = v[3:0];
				tswm_pkg::REG_TILE_WIDTH:    t_w = v[3:0];
				tswm_pkg::REG_CHANNEL_COUNT: chans = v[1:0];
				tswm_pkg::REG_MOTION_LIMIT:  motion = v;
				tswm_pkg::REG_NOISE_GAIN:    noise = v;
				tswm_pkg::REG_OUTPUT_SCALE:  scale = v;
				default: ;
			endcase
		endfunction

		function logic [16:0] calc_tile_weight(int unsigned n, int unsigned ch);
			logic [55:0]  mse_q;
			logic [88:0]  divisor;
			logic [127:0] quo;
			logic [63:0]  y, y2, y3, y4, p;
			if (err_acc == '0) begin
				return 17'h1_0000;
			end
			mse_q = ({16'b0, err_acc} << 16) / 56'(n * ch);
			divisor = 89'(noise) * 89'(mse_q) + (89'(motion) << 16);
			if (divisor == '0) begin
				return '0;
			end
			quo = (128'(mse_q) << 32) / 128'(divisor);
			if (quo >= 128'(1 << 20)) begin
				return '0;
			end
			y = quo[63:0] << 8;
			y2 = (y * y) >> 32;
			y3 = (y2 * y) >> 32;
			y4 = (y3 * y) >> 32;
			p = (64'h1_0000_0000 - y) + (y2 >> 1) + (y4 / 24) - (y3 / 6);
			for (int i = 0; i < 8; i++) begin
				p = (p >= 64'h1_0000_0000) ? 64'h1_0000_0000 : (p * p) >> 32;
			end
			return 17'((p + 64'd32768) >> 16);
		endfunction

		function void note_pixel(tswm_pkg::pixel_t px);
			int unsigned ch, th, tw, n;
			logic [15:0] cv, rv, d;
			logic [16:0] w, wc;
			logic [79:0] prod;
			logic [47:0] cvals [3];
			tswm_pkg::result_t r;
			ch = (chans == 0) ? 1 : chans;
			th = (t_h == 0) ? 1 : (t_h > 8) ? 8 : t_h;
			tw = (t_w == 0) ? 1 : (t_w > 8) ? 8 : t_w;
			if (loaded == 0) begin
				org_r = px.tile_row;
				org_c = px.tile_col;
				crosses_border = (int'(org_r) + th > int'(img_h)) ||
						(int'(org_c) + tw > int'(img_w));
			end
			if (loaded < 64) begin
				for (int j = 0; j < 3; j++) begin
					cv = (j == 0) ? px.cur_ch0 : (j == 1) ? px.cur_ch1 : px.cur_ch2;
					rv = (j == 0) ? px.ref_ch0 : (j == 1) ? px.ref_ch1 : px.ref_ch2;
					if (j < ch) begin
						d = (cv > rv) ? cv - rv : rv - cv;
						err_acc = err_acc + 40'(32'(d) * 32'(d));
					end
				end
				pix_mem[loaded] = {px.cur_ch2, px.cur_ch1, px.cur_ch0};
				win_mem[loaded] = px.window_value;
				loaded++;
			end
			if (!px.last_of_tile) begin
				return;
			end
			n = loaded;
			w = calc_tile_weight(n, ch);
			if (crosses_border) begin
				n = 0;
			end
			for (int k = 0; k < n; k++) begin
				wc = 17'((33'(win_mem[k]) * 33'(w)) >> 15);
				for (int j = 0; j < 3; j++) begin
					cvals[j] = '0;
					if (j < ch) begin
						prod = 80'(pix_mem[k][16*j +: 16]) * 80'(wc) * 80'(scale);
						cvals[j] = (prod[79:64] != '0) ? '1 : prod[63:16];
					end
				end
				r.pixel_row = org_r + 12'(k / tw);
				r.pixel_col = org_c + 12'(k % tw);
				r.contrib_ch0 = cvals[0];
				r.contrib_ch1 = cvals[1];
				r.contrib_ch2 = cvals[2];
				r.weight_contrib = wc;
				r.last_result = (k + 1 == n);
				pending.push_back(r);
			end
			err_acc = '0;
			loaded = 0;
			crosses_border = 1'b0;
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, logic [47:0] got, logic [47:0] want);
			if (got !== want) begin
				report($sformatf("%s got %0h want %0h", name, got, want));
			end
		endtask

		task check_result(tswm_pkg::result_t r);
			tswm_pkg::result_t e;
			if (pending.size() == 0) begin
				report("contribution with none outstanding");
				return;
			end
			e = pending.pop_front();
			compare_field("pixel_row", 48'(r.pixel_row), 48'(e.pixel_row));
			compare_field("pixel_col", 48'(r.pixel_col), 48'(e.pixel_col));
			compare_field("contrib_ch0", r.contrib_ch0, e.contrib_ch0);
			compare_field("contrib_ch1", r.contrib_ch1, e.contrib_ch1);
			compare_field("contrib_ch2", r.contrib_ch2, e.contrib_ch2);
			compare_field("weight_contrib", 48'(r.weight_contrib), 48'(e.weight_contrib));
			compare_field("last_result", 48'(r.last_result), 48'(e.last_result));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	tswm_pkg::pixel_t  pixel;
	logic        strobe;
	tswm_pkg::result_t result;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	merge_scoreboard sb = new();
	int items = 0;
	bit no_gaps;

	tile_similarity_weighted_merge DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.strobe(strobe),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (strobe === 1'b1) begin
			sb.check_result(result);
		end
		if (start && busy === 1'b0) begin
			sb.note_pixel(pixel);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	task automatic program_regs(logic [12:0] ih, logic [12:0] iw, logic [3:0] th,
			logic [3:0] tw, logic [1:0] ch, logic [31:0] ml, logic [31:0] ng,
			logic [31:0] os);
		logic [31:0] vals [8];
		tswm_pkg::reg_idx_t idx;
		vals = '{32'(ih), 32'(iw), 32'(th), 32'(tw), 32'(ch), ml, ng, os};
		idx = tswm_pkg::REG_IMAGE_HEIGHT;
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= vals[i];
			sb.set_reg(idx, vals[i]);
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(tswm_pkg::pixel_t px);
		int gap;
		start <= 1'b1;
		pixel <= px;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
		items++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic send_tile(int npix, logic [11:0] row, logic [11:0] col,
			diff_t diff_mode);
		tswm_pkg::pixel_t px;
		logic [15:0] c [3];
		logic [15:0] r [3];
		for (int i = 0; i < npix; i++) begin
			for (int j = 0; j < 3; j++) begin
				c[j] = $urandom();
				case (diff_mode)
					DIFF_EQUAL:  r[j] = c[j];
					DIFF_SMALL:  r[j] = c[j] + 16'($urandom_range(0, 31)) - 16'd15;
					DIFF_RANDOM: r[j] = $urandom();
					default: begin
						c[j] = '1;
						r[j] = '0;
					end
				endcase
			end
			px.tile_row = (i == 0) ? row : 12'($urandom());
			px.tile_col = (i == 0) ? col : 12'($urandom());
			{px.cur_ch0, px.cur_ch1, px.cur_ch2} = {c[0], c[1], c[2]};
			{px.ref_ch0, px.ref_ch1, px.ref_ch2} = {r[0], r[1], r[2]};
			px.window_value = ($urandom_range(0, 9) == 0) ? 16'd32768 :
					16'($urandom_range(0, 32768));
			px.last_of_tile = (i == npix - 1);
			send_pixel(px);
		end
	endtask

	task automatic random_tile();
		int th, tw, ih, iw, npix, sel;
		logic [11:0] row, col;
		th = (sb.t_h == 0) ? 1 : (sb.t_h > 8) ? 8 : sb.t_h;
		tw = (sb.t_w == 0) ? 1 : (sb.t_w > 8) ? 8 : sb.t_w;
		ih = sb.img_h;
		iw = sb.img_w;
		sel = $urandom_range(0, 99);
		if (sel < 75) begin
			row = (ih >= th) ? 12'($urandom_range(0, ih - th)) : '0;
			col = (iw >= tw) ? 12'($urandom_range(0, iw - tw)) : '0;
		end else if (sel < 88) begin
			row = 12'(ih - th + $urandom_range(0, 1));
			col = 12'(iw - tw + $urandom_range(0, 1));
		end else begin
			row = $urandom();
			col = $urandom();
		end
		sel = $urandom_range(0, 99);
		if (sel < 80) begin
			npix = th * tw;
		end else if (sel < 97) begin
			npix = $urandom_range(1, 64);
		end else begin
			npix = $urandom_range(65, 70);
		end
		send_tile(npix, row, col,
				($urandom_range(0, 9) < 6) ? DIFF_SMALL : diff_t'($urandom_range(0, 3)));
	endtask

	initial begin
		logic [31:0] ml, ng, os;
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_gaps = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default registers, then small tiles and edge cases
		send_tile(1, 12'd0, 12'd0, DIFF_EQUAL);
		drain();
		program_regs(13'd1080, 13'd1920, 4'd2, 4'd2, 2'd3, 32'd65536, 32'd65536,
				32'd65536);
		send_tile(4, 12'd0, 12'd0, DIFF_FULL);
		send_tile(4, 12'd1078, 12'd1918, DIFF_EQUAL);
		send_tile(4, 12'd1079, 12'd0, DIFF_RANDOM);
		send_tile(4, 12'hFFF, 12'hFFF, DIFF_SMALL);
		drain();
		program_regs(13'd4096, 13'd4096, 4'd1, 4'd1, 2'd1, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send_tile(1, 12'hFFF, 12'hFFF, DIFF_FULL);
		send_tile(1, 12'd5, 12'd7, DIFF_EQUAL);
		send_tile(1, 12'd100, 12'd200, DIFF_RANDOM);
		drain();

		for (int ph = 0; items < 460; ph++) begin
			no_gaps = (ph % 4 == 1);
			case (ph)
				0: program_regs(13'd1, 13'd1, 4'd0, 4'd0, 2'd0, 32'hFFFF_FFFF,
						32'hFFFF_FFFF, 32'd1);
				1: program_regs(13'd64, 13'd64, 4'd15, 4'd15, 2'd2, 32'd100,
						32'd262144, 32'd65536000);
				2: program_regs(13'd8, 13'd8, 4'd8, 4'd8, 2'd3, 32'd4194304, 32'd0,
						32'd65536);
				3: program_regs(13'd1080, 13'd1920, 4'd8, 4'd8, 2'd3, 32'd65536,
						32'd65536, 32'd65536);
				default: begin
					ml = ($urandom_range(0, 3) == 0) ? $urandom() :
							$urandom_range(0, 32'd400 << 16);
					ng = ($urandom_range(0, 3) == 0) ? $urandom() :
							$urandom_range(0, 32'd4 << 16);
					os = ($urandom_range(0, 3) == 0) ? $urandom() :
							$urandom_range(0, 32'd16 << 16);
					program_regs(13'($urandom_range(1, 4096)),
							13'($urandom_range(1, 4096)),
							4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
							2'($urandom_range(0, 3)), ml, ng, os);
				end
			endcase
			for (int base = items; items - base < 45 && items < 460; ) begin
				random_tile();
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
